### sv/text_to_integer_parser_macros.svh
// assertion macros for the text to integer parser
`ifndef TEXT_TO_INTEGER_PARSER_MACROS_SVH
`define TEXT_TO_INTEGER_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked at every rising edge out of reset
`define TTIP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define TTIP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define TTIP_ASSERT_IMP(lbl, ante, cons)

`define TTIP_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### sv/ttip_pkg.sv
// shared types, constants and helpers for the text to integer parser
package ttip_pkg;

  // saturating character count
  localparam int COUNT_LIMIT = 255;
  localparam int CNT_W = ($clog2(COUNT_LIMIT + 1) > 8) ? $clog2(COUNT_LIMIT + 1) : 8;

  // radix handling
  localparam logic [4:0] BASE_MIN   = 5'd2;
  localparam logic [4:0] BASE_HEX   = 5'd16;
  localparam logic [4:0] BASE_RESET = 5'd10;

  // characters of interest
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] HEX_OFF  = 8'd10;

  // register indexes (word address bits)
  localparam logic [1:0] REG_NUMBER_BASE = 2'd0;
  localparam logic [1:0] REG_SIGNED_MODE = 2'd1;
  localparam logic [1:0] REG_WIDE_MODE   = 2'd2;

  // magnitude limits and saturated results
  localparam logic [63:0] S64_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] S32_MAX  = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] S32_MAGN = 64'h0000_0000_8000_0000;
  localparam logic [63:0] S32_MIN  = 64'hFFFF_FFFF_8000_0000;
  localparam logic [63:0] U64_MAX  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] U32_MAX  = 64'h0000_0000_FFFF_FFFF;

  typedef enum logic [1:0] {
    PH_START,
    PH_SIGN,
    PH_LEADZ,
    PH_DIGITS
  } phase_t;

  typedef struct packed {
    logic [4:0] base_eff;
    logic       signed_mode;
    logic       wide_mode;
  } cfg_t;

  typedef struct packed {
    logic       is_nul;
    logic       is_minus;
    logic       is_x;
    logic       is_zero;
    logic       is_digit;
    logic [3:0] digit;
  } char_cls_t;

  typedef struct packed {
    logic [63:0] value;
    logic        range_error;
    logic [7:0]  count;
  } result_t;

  // clamp the radix register into 2..16
  function automatic logic [4:0] eff_base(input logic [4:0] b);
    logic [4:0] r;
    if (b < BASE_MIN) begin
      r = BASE_MIN;
    end else if (b > BASE_HEX) begin
      r = BASE_HEX;
    end else begin
      r = b;
    end
    return r;
  endfunction

endpackage

### sv/ttip_char_dec.sv
// character classifier: digit value and special characters
module ttip_char_dec (
  input  logic [7:0]          text_char,
  input  logic                hex_en,
  output ttip_pkg::char_cls_t cls
);

  logic [7:0] dec_val;
  logic [7:0] up_val;
  logic [7:0] lo_val;
  logic       is_dec;
  logic       is_up;
  logic       is_lo;

  assign dec_val = text_char - ttip_pkg::CH_ZERO;
  assign up_val  = text_char - ttip_pkg::CH_UA + ttip_pkg::HEX_OFF;
  assign lo_val  = text_char - ttip_pkg::CH_LA + ttip_pkg::HEX_OFF;

  assign is_dec = (text_char >= ttip_pkg::CH_ZERO) && (text_char <= ttip_pkg::CH_NINE);
  assign is_up  = hex_en && (text_char >= ttip_pkg::CH_UA) && (text_char <= ttip_pkg::CH_UF);
  assign is_lo  = hex_en && (text_char >= ttip_pkg::CH_LA) && (text_char <= ttip_pkg::CH_LF);

  always_comb begin
    cls.is_nul   = (text_char == ttip_pkg::CH_NUL);
    cls.is_minus = (text_char == ttip_pkg::CH_MINUS);
    cls.is_x     = (text_char == ttip_pkg::CH_X);
    cls.is_zero  = (text_char == ttip_pkg::CH_ZERO);
    cls.is_digit = is_dec || is_up || is_lo;
    if (is_up) begin
      cls.digit = up_val[3:0];
    end else if (is_lo) begin
      cls.digit = lo_val[3:0];
    end else begin
      cls.digit = dec_val[3:0];
    end
  end

endmodule

### sv/ttip_step.sv
// per-text parse state and the combinational character step
module ttip_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic                eot,
  input  ttip_pkg::char_cls_t cls,
  input  ttip_pkg::cfg_t      cfg,
  output ttip_pkg::result_t   res
);

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_STOP,
    ACT_SIGN,
    ACT_PREFIX,
    ACT_DIGIT,
    ACT_OVF
  } act_t;

  logic [63:0]                 acc_r;
  logic                        neg_r;
  ttip_pkg::phase_t            phase_r;
  logic                        stop_r;
  logic                        ovf_r;
  logic [ttip_pkg::CNT_W-1:0]  cnt_r;

  logic [63:0]                 acc_nxt;
  logic                        neg_nxt;
  ttip_pkg::phase_t            phase_nxt;
  logic                        stop_nxt;
  logic                        ovf_nxt;
  logic [ttip_pkg::CNT_W-1:0]  cnt_nxt;
  logic [ttip_pkg::CNT_W-1:0]  cnt_inc;

  act_t        act;
  logic        base16;
  logic [63:0] lim;
  logic [68:0] prod;
  logic [69:0] sum;
  logic        digit_ovf;
  logic        is_neg;
  logic [63:0] sat_val;

  assign base16 = (cfg.base_eff == ttip_pkg::BASE_HEX);

  // magnitude limit for current modes and sign
  always_comb begin
    if (cfg.signed_mode) begin
      if (cfg.wide_mode) begin
        lim = neg_r ? ttip_pkg::S64_MIN : ttip_pkg::S64_MAX;
      end else begin
        lim = neg_r ? ttip_pkg::S32_MAGN : ttip_pkg::S32_MAX;
      end
    end else begin
      lim = cfg.wide_mode ? ttip_pkg::U64_MAX : ttip_pkg::U32_MAX;
    end
  end

  // exact test: acc*base + digit above the limit
  assign prod      = {5'd0, acc_r} * {64'd0, cfg.base_eff};
  assign sum       = {1'b0, prod} + {66'd0, cls.digit};
  assign digit_ovf = sum > {6'd0, lim};

  assign cnt_inc = (cnt_r < ttip_pkg::CNT_W'(ttip_pkg::COUNT_LIMIT)) ?
                   cnt_r + 1'b1 : cnt_r;

  always_comb begin
    if (stop_r) begin
      act = ACT_NONE;
    end else if (cls.is_nul) begin
      act = ACT_STOP;
    end else if (phase_r == ttip_pkg::PH_START && cls.is_minus && cfg.signed_mode) begin
      act = ACT_SIGN;
    end else if (phase_r == ttip_pkg::PH_LEADZ && cls.is_x && base16) begin
      act = ACT_PREFIX;
    end else if (!cls.is_digit) begin
      act = ACT_STOP;
    end else if (digit_ovf) begin
      act = ACT_OVF;
    end else begin
      act = ACT_DIGIT;
    end
  end

  // phase next state
  always_comb begin
    unique case (act)
      ACT_SIGN:   phase_nxt = ttip_pkg::PH_SIGN;
      ACT_PREFIX: phase_nxt = ttip_pkg::PH_DIGITS;
      ACT_DIGIT: begin
        if ((phase_r == ttip_pkg::PH_START || phase_r == ttip_pkg::PH_SIGN) && cls.is_zero) begin
          phase_nxt = ttip_pkg::PH_LEADZ;
        end else begin
          phase_nxt = ttip_pkg::PH_DIGITS;
        end
      end
      default:    phase_nxt = phase_r;
    endcase
  end

  // datapath updates
  always_comb begin
    acc_nxt  = acc_r;
    neg_nxt  = neg_r;
    stop_nxt = stop_r;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    unique case (act)
      ACT_NONE: ;
      ACT_STOP: stop_nxt = 1'b1;
      ACT_SIGN: begin
        neg_nxt = 1'b1;
        cnt_nxt = cnt_inc;
      end
      ACT_PREFIX: cnt_nxt = cnt_inc;
      ACT_DIGIT: begin
        acc_nxt = sum[63:0];
        cnt_nxt = cnt_inc;
      end
      ACT_OVF: begin
        ovf_nxt  = 1'b1;
        stop_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      neg_r   <= 1'b0;
      phase_r <= ttip_pkg::PH_START;
      stop_r  <= 1'b0;
      ovf_r   <= 1'b0;
      cnt_r   <= '0;
    end else if (step_en) begin
      if (eot) begin
        acc_r   <= '0;
        neg_r   <= 1'b0;
        phase_r <= ttip_pkg::PH_START;
        stop_r  <= 1'b0;
        ovf_r   <= 1'b0;
        cnt_r   <= '0;
      end else begin
        acc_r   <= acc_nxt;
        neg_r   <= neg_nxt;
        phase_r <= phase_nxt;
        stop_r  <= stop_nxt;
        ovf_r   <= ovf_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  // result as seen after this character
  assign is_neg = cfg.signed_mode && neg_nxt;

  always_comb begin
    if (cfg.signed_mode) begin
      if (cfg.wide_mode) begin
        sat_val = is_neg ? ttip_pkg::S64_MIN : ttip_pkg::S64_MAX;
      end else begin
        sat_val = is_neg ? ttip_pkg::S32_MIN : ttip_pkg::S32_MAX;
      end
    end else begin
      sat_val = cfg.wide_mode ? ttip_pkg::U64_MAX : ttip_pkg::U32_MAX;
    end
  end

  always_comb begin
    if (ovf_nxt) begin
      res.value = sat_val;
    end else if (is_neg) begin
      res.value = 64'd0 - acc_nxt;
    end else begin
      res.value = acc_nxt;
    end
    res.range_error = ovf_nxt;
    res.count       = cnt_nxt[7:0];
  end

endmodule

### sv/text_to_integer_parser.sv
// top level: input register, configuration registers, parse step and result register
// a result is registered when its end-of-text item leaves the input register
// throughput: one item per cycle unless an end-of-text item waits, with a combinational multiply-add and limit compare
// an end-of-text item waits in the input register while the result register is full
// reset (synchronous, rst_n low) empties both registers, clears the parse state and
// sets number_base to 10, signed_mode to 1 and wide_mode to 0
`include "text_to_integer_parser_macros.svh"

module text_to_integer_parser (
  input  logic        clk,
  input  logic        rst_n,
  // character items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_char,
  input  logic        in_end_of_text,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_parsed_value,
  output logic        out_range_error,
  output logic [7:0]  out_chars_consumed,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // configuration registers
  logic [4:0] number_base_r;
  logic       signed_mode_r;
  logic       wide_mode_r;
  logic       cfg_wr;

  // input register (payload unreset)
  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_eot_r;

  // result register
  logic        out_valid_r;
  logic [63:0] out_value_r;
  logic        out_err_r;
  logic [7:0]  out_cnt_r;

  logic out_free;
  logic s1_adv;
  logic in_fire;
  logic res_load;

  ttip_pkg::cfg_t      cfg;
  ttip_pkg::char_cls_t cls;
  ttip_pkg::result_t   res;

  // ---------------------------------------------------------------------------
  // configuration port: writes complete in the access phase, no wait states
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_base_r <= ttip_pkg::BASE_RESET;
      signed_mode_r <= 1'b1;
      wide_mode_r   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        ttip_pkg::REG_NUMBER_BASE: number_base_r <= cfg_pwdata[4:0];
        ttip_pkg::REG_SIGNED_MODE: signed_mode_r <= cfg_pwdata[0];
        ttip_pkg::REG_WIDE_MODE:   wide_mode_r   <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      ttip_pkg::REG_NUMBER_BASE: cfg_prdata = {27'd0, number_base_r};
      ttip_pkg::REG_SIGNED_MODE: cfg_prdata = {31'd0, signed_mode_r};
      ttip_pkg::REG_WIDE_MODE:   cfg_prdata = {31'd0, wide_mode_r};
      default:                   cfg_prdata = 32'd0;
    endcase
  end

  // radix clamped once here, shared by decoder and step
  assign cfg.base_eff    = ttip_pkg::eff_base(number_base_r);
  assign cfg.signed_mode = signed_mode_r;
  assign cfg.wide_mode   = wide_mode_r;

  // ---------------------------------------------------------------------------
  // handshake: an item leaves the input register when it produces no result,
  // or when the result register is empty or being drained this cycle
  // ---------------------------------------------------------------------------
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!s1_eot_r || out_free);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;
  assign res_load = s1_adv && s1_eot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char_r <= in_text_char;
      s1_eot_r  <= in_end_of_text;
    end
  end

  // ---------------------------------------------------------------------------
  // parse step: classify the held character and advance the text state
  // ---------------------------------------------------------------------------
  ttip_char_dec u_char_dec (
    .text_char (s1_char_r),
    .hex_en    (cfg.base_eff == ttip_pkg::BASE_HEX),
    .cls       (cls)
  );

  ttip_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_adv),
    .eot     (s1_eot_r),
    .cls     (cls),
    .cfg     (cfg),
    .res     (res)
  );

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_value_r <= res.value;
      out_err_r   <= res.range_error;
      out_cnt_r   <= res.count;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_parsed_value   = out_value_r;
  assign out_range_error    = out_err_r;
  assign out_chars_consumed = out_cnt_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // a result is only written into a free result register
  `TTIP_ASSERT_IMP(a_load_into_free, res_load, !out_valid_r || out_ready)
  // a blocked end-of-text item stays put along with the pending result
  `TTIP_ASSERT_NXT(a_eot_held, s1_valid_r && s1_eot_r && out_valid_r && !out_ready, s1_valid_r && s1_eot_r && out_valid_r)
  // a range error always comes with one of the saturated values
  `TTIP_ASSERT_IMP(a_err_saturated, out_valid_r && out_err_r, out_value_r == ttip_pkg::S64_MAX || out_value_r == ttip_pkg::S64_MIN || out_value_r == ttip_pkg::S32_MAX || out_value_r == ttip_pkg::S32_MIN || out_value_r == ttip_pkg::U64_MAX || out_value_r == ttip_pkg::U32_MAX)

endmodule
